// File: sv/rrt_nni_pkg.sv
// shared types and constants for the rrt nearest node insert block
`timescale 1ns / 1ps
package rrt_nni_pkg;

  localparam int COORD_W   = 16;
  localparam int MAX_NODES = 1024;
  localparam int NUM_CELLS = 4;
  localparam int ROWS      = MAX_NODES / NUM_CELLS;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int LANE_W    = $clog2(NUM_CELLS);
  localparam int ROW_W     = IDX_W - LANE_W;
  localparam int CNT_W     = IDX_W + 1;
  localparam int ABS_W     = COORD_W + 1;
  localparam int SQ_W      = 2 * ABS_W;
  localparam int DIST_W    = SQ_W + 1;
  localparam int ADDR_W    = 4;

  localparam logic [ADDR_W-1:0] REG_X_MIN = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] REG_X_MAX = ADDR_W'(4);
  localparam logic [ADDR_W-1:0] REG_Y_MIN = ADDR_W'(8);
  localparam logic [ADDR_W-1:0] REG_Y_MAX = ADDR_W'(12);

  localparam logic signed [COORD_W-1:0] X_MIN_RST = COORD_W'(7680);
  localparam logic signed [COORD_W-1:0] X_MAX_RST = COORD_W'(10240);
  localparam logic signed [COORD_W-1:0] Y_MIN_RST = COORD_W'(7680);
  localparam logic signed [COORD_W-1:0] Y_MAX_RST = COORD_W'(10240);

  typedef enum logic [1:0] {
    ST_ROOT   = 2'd0,
    ST_PARENT = 2'd1,
    ST_OBST   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ROW_W-1:0]  row;
    logic              best_vld;
    logic [DIST_W-1:0] best_dist;
    logic [IDX_W-1:0]  best_idx;
  } tok_t;

endpackage

// File: sv/rrt_nni_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module rrt_nni_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rrt_nni_cell.sv
// one search cell: a bank of nodes, distance pipeline and running minimum
`timescale 1ns / 1ps
module rrt_nni_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [rrt_nni_pkg::LANE_W-1:0]        lane_id,
  input  logic [rrt_nni_pkg::CNT_W-1:0]         node_count,
  input  logic                                  wr_en,
  input  logic [rrt_nni_pkg::ROW_W-1:0]         wr_row,
  input  logic signed [rrt_nni_pkg::COORD_W-1:0] wr_x,
  input  logic signed [rrt_nni_pkg::COORD_W-1:0] wr_y,
  input  logic signed [rrt_nni_pkg::COORD_W-1:0] qx,
  input  logic signed [rrt_nni_pkg::COORD_W-1:0] qy,
  input  rrt_nni_pkg::tok_t                     tok_in,
  output rrt_nni_pkg::tok_t                     tok_out
);

  localparam int CW = rrt_nni_pkg::COORD_W;
  localparam int AW = rrt_nni_pkg::ABS_W;

  logic [2*CW-1:0] rdata;
  rrt_nni_pkg::tok_t t1_r, t2_r, t3_r, out_r;
  logic c1_r, c2_r, c3_r;
  logic [AW-1:0] ax_r, ay_r;
  logic [rrt_nni_pkg::SQ_W-1:0] sqx_r, sqy_r;
  logic signed [AW-1:0] dx, dy;
  logic [rrt_nni_pkg::DIST_W-1:0] sum;
  logic consider;

  rrt_nni_ram #(
    .WIDTH(2 * CW),
    .DEPTH(rrt_nni_pkg::ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_row),
    .wdata({wr_y, wr_x}),
    .raddr(tok_in.row),
    .rdata(rdata)
  );

  // only nodes below the fill count take part
  assign consider = {1'b0, tok_in.row, lane_id} < node_count;

  always_comb begin
    dx = AW'($signed(rdata[CW-1:0])) - AW'(qx);
    dy = AW'($signed(rdata[2*CW-1:CW])) - AW'(qy);
    sum = rrt_nni_pkg::DIST_W'(sqx_r) + rrt_nni_pkg::DIST_W'(sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r.valid  <= 1'b0;
      t2_r.valid  <= 1'b0;
      t3_r.valid  <= 1'b0;
      out_r.valid <= 1'b0;
    end else begin
      t1_r  <= tok_in;
      t2_r  <= t1_r;
      t3_r  <= t2_r;
      out_r <= t3_r;
      // strict compare keeps the lower index on a tie
      if (t3_r.valid && c3_r && (!t3_r.best_vld || sum < t3_r.best_dist)) begin
        out_r.best_vld  <= 1'b1;
        out_r.best_dist <= sum;
        out_r.best_idx  <= {t3_r.row, lane_id};
      end
    end
  end

  always_ff @(posedge clk) begin
    c1_r  <= consider;
    c2_r  <= c1_r;
    c3_r  <= c2_r;
    ax_r  <= dx[AW-1] ? AW'(-dx) : AW'(dx);
    ay_r  <= dy[AW-1] ? AW'(-dy) : AW'(dy);
    sqx_r <= ax_r * ax_r;
    sqy_r <= ay_r * ay_r;
  end

  assign tok_out = out_r;

endmodule

// File: sv/rrt_nearest_node_insert.sv
// rrt node insert: obstacle test, node store and nearest parent search
//
// usage: each in_ beat carries one candidate point (signed q8.8 x and y).
// a point strictly inside the obstacle rectangle gets status 2, a point that
// arrives with the store full gets status 3; otherwise it is stored at the
// next free index and one out_ beat returns status, node index and parent.
// the nodes are spread over a row of 4 cells, node i in cell i mod 4. while
// scanning, a search token enters the first cell each cycle, one per row of 4
// nodes, and moves along the cells, carrying the nearest node so far.
// rejects and the root go straight to the done state; an insert with stored
// nodes issues one token per row in use, then waits for the last token to
// leave the cell chain. each result enters the out_ register once it is free.
// one item is in work at a time; in_tready is high only while idle, so the
// next in_ beat is taken in the idle state after the out_ register is loaded.
// a finished result waits in the out_ register, and the next point may be
// accepted meanwhile; its result holds until out_tready takes the first.
// reset empties the store and loads the default obstacle (30.0..40.0).
// write the obstacle regs over the cfg_ port only while idle; not enforced.
`timescale 1ns / 1ps
module rrt_nearest_node_insert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // point_x, point_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // node_index, parent_index, zero pad
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CW = rrt_nni_pkg::COORD_W;
  localparam int NC = rrt_nni_pkg::NUM_CELLS;
  localparam int IW = rrt_nni_pkg::IDX_W;
  localparam int LW = rrt_nni_pkg::LANE_W;
  localparam int RW = rrt_nni_pkg::ROW_W;
  localparam int NW = rrt_nni_pkg::CNT_W;

  rrt_nni_pkg::state_t state_r, state_nxt;

  logic signed [CW-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic signed [CW-1:0] px_r, py_r, in_x, in_y;
  logic [NW-1:0] count_r, cnt_m1;
  logic [RW-1:0] row_r, last_row;
  rrt_nni_pkg::status_t res_st_r;
  logic [IW-1:0] res_idx_r, res_par_r;
  logic wr_pend_r;
  logic acc_vld_r;
  logic [rrt_nni_pkg::DIST_W-1:0] acc_dist_r;
  logic [IW-1:0] acc_idx_r, merged_idx;
  logic out_valid_r;
  rrt_nni_pkg::status_t out_st_r;
  logic [IW-1:0] out_idx_r, out_par_r;
  logic in_acc, hit_obst, full, done_load, take_tok;
  rrt_nni_pkg::tok_t issue;
  rrt_nni_pkg::tok_t chain [NC+1];
  logic cfg_wr;

  assign in_x = in_tdata[CW-1:0];
  assign in_y = in_tdata[2*CW-1:CW];
  assign in_acc = in_tvalid && in_tready;
  assign hit_obst = (in_x > x_min_r) && (in_x < x_max_r) &&
                    (in_y > y_min_r) && (in_y < y_max_r);
  assign full = count_r >= NW'(rrt_nni_pkg::MAX_NODES);
  assign cnt_m1 = count_r - NW'(1);
  assign last_row = cnt_m1[IW-1:LW];

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr)
      rrt_nni_pkg::REG_X_MIN: cfg_prdata = 32'($signed(x_min_r));
      rrt_nni_pkg::REG_X_MAX: cfg_prdata = 32'($signed(x_max_r));
      rrt_nni_pkg::REG_Y_MIN: cfg_prdata = 32'($signed(y_min_r));
      rrt_nni_pkg::REG_Y_MAX: cfg_prdata = 32'($signed(y_max_r));
      default:                cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= rrt_nni_pkg::X_MIN_RST;
      x_max_r <= rrt_nni_pkg::X_MAX_RST;
      y_min_r <= rrt_nni_pkg::Y_MIN_RST;
      y_max_r <= rrt_nni_pkg::Y_MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        rrt_nni_pkg::REG_X_MIN[3:2]: x_min_r <= cfg_pwdata[CW-1:0];
        rrt_nni_pkg::REG_X_MAX[3:2]: x_max_r <= cfg_pwdata[CW-1:0];
        rrt_nni_pkg::REG_Y_MIN[3:2]: y_min_r <= cfg_pwdata[CW-1:0];
        rrt_nni_pkg::REG_Y_MAX[3:2]: y_max_r <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // cell chain
  assign chain[0] = issue;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    rrt_nni_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .lane_id   (LW'(k)),
      .node_count(count_r),
      .wr_en     (done_load && wr_pend_r && (res_idx_r[LW-1:0] == LW'(k))),
      .wr_row    (res_idx_r[IW-1:LW]),
      .wr_x      (px_r),
      .wr_y      (py_r),
      .qx        (px_r),
      .qy        (py_r),
      .tok_in    (chain[k]),
      .tok_out   (chain[k+1])
    );
  end

  // rows arrive in order, so a strict compare keeps the lower index
  assign take_tok = chain[NC].valid && chain[NC].best_vld &&
                    (!acc_vld_r || chain[NC].best_dist < acc_dist_r);
  assign merged_idx = take_tok ? chain[NC].best_idx : acc_idx_r;

  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    done_load      = 1'b0;
    issue          = '0;
    issue.row      = row_r;
    issue.last     = row_r == last_row;
    unique case (state_r)
      rrt_nni_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (hit_obst || full || count_r == NW'(0)) begin
            state_nxt = rrt_nni_pkg::S_DONE;
          end else begin
            state_nxt = rrt_nni_pkg::S_SCAN;
          end
        end
      end
      rrt_nni_pkg::S_SCAN: begin
        issue.valid = 1'b1;
        if (row_r == last_row) begin
          state_nxt = rrt_nni_pkg::S_WAIT;
        end
      end
      rrt_nni_pkg::S_WAIT: begin
        if (chain[NC].valid && chain[NC].last) begin
          state_nxt = rrt_nni_pkg::S_DONE;
        end
      end
      rrt_nni_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          done_load = 1'b1;
          state_nxt = rrt_nni_pkg::S_IDLE;
        end
      end
      default: state_nxt = rrt_nni_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrt_nni_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      acc_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done_load) begin
        out_valid_r <= 1'b1;
        if (wr_pend_r) begin
          count_r <= count_r + NW'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc) begin
        acc_vld_r <= 1'b0;
      end else if (take_tok) begin
        acc_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r      <= in_x;
      py_r      <= in_y;
      row_r     <= '0;
      res_par_r <= '0;
      if (hit_obst) begin
        res_st_r  <= rrt_nni_pkg::ST_OBST;
        res_idx_r <= '0;
        wr_pend_r <= 1'b0;
      end else if (full) begin
        res_st_r  <= rrt_nni_pkg::ST_FULL;
        res_idx_r <= '0;
        wr_pend_r <= 1'b0;
      end else begin
        res_st_r  <= (count_r == NW'(0)) ? rrt_nni_pkg::ST_ROOT
                                         : rrt_nni_pkg::ST_PARENT;
        res_idx_r <= count_r[IW-1:0];
        wr_pend_r <= 1'b1;
      end
    end else begin
      if (state_r == rrt_nni_pkg::S_SCAN) begin
        row_r <= row_r + RW'(1);
      end
      if (state_r == rrt_nni_pkg::S_WAIT && chain[NC].valid && chain[NC].last) begin
        res_par_r <= merged_idx;
      end
    end
    if (take_tok) begin
      acc_dist_r <= chain[NC].best_dist;
      acc_idx_r  <= chain[NC].best_idx;
    end
    if (done_load) begin
      out_st_r  <= res_st_r;
      out_idx_r <= res_idx_r;
      out_par_r <= res_par_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {4'd0, out_par_r, out_idx_r};

endmodule

// File: tb/rrt_nearest_node_insert_test.sv
// self-checking testbench for the rrt nearest node insert block
`timescale 1ns / 1ps
module rrt_nearest_node_insert_test;

  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
  } point_t;

  typedef struct {
    rrt_nni_pkg::status_t status;
    logic [9:0]           node;
    logic [9:0]           parent;
  } insert_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // point_x, point_y
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // node_index, parent_index, zero pad
  logic [1:0]  out_tuser;       // status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rrt_nearest_node_insert DUT (.*);

  // model of the obstacle and node store
  logic signed [15:0] obs_x_lo = rrt_nni_pkg::X_MIN_RST, obs_x_hi = rrt_nni_pkg::X_MAX_RST;
  logic signed [15:0] obs_y_lo = rrt_nni_pkg::Y_MIN_RST, obs_y_hi = rrt_nni_pkg::Y_MAX_RST;
  logic signed [15:0] tree_x [rrt_nni_pkg::MAX_NODES];
  logic signed [15:0] tree_y [rrt_nni_pkg::MAX_NODES];
  int unsigned        tree_count = 0;

  point_t      points_pending[$];
  insert_res_t inserts_expected[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          send_paused = 1'b0;
  int          recv_hold = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("rrt_nearest_node_insert_test: FAIL");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic longint unsigned sq_dist(logic signed [15:0] ax, logic signed [15:0] ay,
                                              logic signed [15:0] bx, logic signed [15:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic void predict_insert(point_t p);
    insert_res_t r;
    longint unsigned best, d;
    r.node = '0;
    r.parent = '0;
    if (p.px > obs_x_lo && p.px < obs_x_hi && p.py > obs_y_lo && p.py < obs_y_hi) begin
      r.status = rrt_nni_pkg::ST_OBST;
    end else if (tree_count >= rrt_nni_pkg::MAX_NODES) begin
      r.status = rrt_nni_pkg::ST_FULL;
    end else begin
      r.node = tree_count[9:0];
      if (tree_count == 0) begin
        r.status = rrt_nni_pkg::ST_ROOT;
      end else begin
        r.status = rrt_nni_pkg::ST_PARENT;
        best = sq_dist(tree_x[0], tree_y[0], p.px, p.py);
        for (int i = 1; i < tree_count; i++) begin
          d = sq_dist(tree_x[i], tree_y[i], p.px, p.py);
          if (d < best) begin
            best = d;
            r.parent = i[9:0];
          end
        end
      end
      tree_x[tree_count] = p.px;
      tree_y[tree_count] = p.py;
      tree_count++;
    end
    inserts_expected = {inserts_expected, r};
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_insert(points_pending.pop_front());
      if (!(in_tvalid && !in_tready)) begin
        if (points_pending.size() > 0 && !send_paused &&
            $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {points_pending[0].py, points_pending[0].px};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (inserts_expected.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          insert_res_t e;
          e = inserts_expected.pop_front();
          if (out_tuser !== e.status)
            report($sformatf("status %0d, want %0d", out_tuser, e.status));
          if (out_tdata[9:0] !== e.node)
            report($sformatf("node %0d, want %0d", out_tdata[9:0], e.node));
          if (out_tdata[19:10] !== e.parent)
            report($sformatf("parent %0d, want %0d", out_tdata[19:10], e.parent));
        end
      end
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic wait_drained();
    while (points_pending.size() > 0 || inserts_expected.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic signed [15:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {{16{val[15]}}, val};
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (addr)
      rrt_nni_pkg::REG_X_MIN: obs_x_lo = val;
      rrt_nni_pkg::REG_X_MAX: obs_x_hi = val;
      rrt_nni_pkg::REG_Y_MIN: obs_y_lo = val;
      default:                obs_y_hi = val;
    endcase
  endtask

  task automatic set_obstacle(input logic signed [15:0] xl, xh, yl, yh);
    write_reg(rrt_nni_pkg::REG_X_MIN, xl);
    write_reg(rrt_nni_pkg::REG_X_MAX, xh);
    write_reg(rrt_nni_pkg::REG_Y_MIN, yl);
    write_reg(rrt_nni_pkg::REG_Y_MAX, yh);
  endtask

  task automatic push_point(input int x, input int y);
    point_t p;
    p.px = x[15:0];
    p.py = y[15:0];
    points_pending = {points_pending, p};
  endtask

  task automatic push_random(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(2);
      if (k == 0) push_point($urandom, $urandom);
      else if (k == 1) push_point(($urandom_range(8) - 4) * 64, ($urandom_range(8) - 4) * 64);
      else push_point(obs_x_lo + $urandom_range(8) - 4 + $urandom_range(1) * (obs_x_hi - obs_x_lo),
                      obs_y_lo + $urandom_range(3000) - 500);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: root, tie on equal distance, boundaries, inside, extremes
    push_point(0, 0);
    push_point(256, 0);
    push_point(-256, 0);
    push_point(128, 0);
    push_point(0, 0);
    push_point(8000, 8000);
    push_point(7680, 8000);
    push_point(10240, 8000);
    push_point(8000, 7680);
    push_point(8000, 10240);
    push_point(7681, 10239);
    push_point(-32768, -32768);
    push_point(32767, 32767);
    push_point(-32768, 32767);
    push_point(32767, -32768);
    push_point(-1, -1);
    wait_drained();

    // no idling, default obstacle, with a long receiver hold-off
    push_random(60);
    recv_hold = 2000;
    push_random(60);
    wait_drained();

    // full-range obstacle
    set_obstacle(-32768, 32767, -32768, 32767);
    send_idle_pct = 80;
    push_point(0, 0);
    push_point(-32768, 0);
    push_point(32767, 5);
    push_random(130);
    wait_drained();

    // inverted and empty obstacle
    set_obstacle(32767, -32768, 100, 100);
    send_idle_pct = 0;
    recv_idle_pct = 80;
    push_random(70);
    // sender pause until all results are back
    while (points_pending.size() > 0) @(posedge clk);
    send_paused = 1'b1;
    while (inserts_expected.size() > 0 || in_tvalid) @(posedge clk);
    repeat (20) @(posedge clk);
    send_paused = 1'b0;
    push_random(70);
    wait_drained();

    // random obstacle
    set_obstacle($urandom_range(2000) - 1000, $urandom_range(4000) + 1000,
                 $urandom_range(2000) - 1000, $urandom_range(4000) + 1000);
    send_idle_pct = 26;
    recv_idle_pct = 26;
    push_random(140);
    wait_drained();

    // default obstacle again
    send_idle_pct = 0;
    set_obstacle(rrt_nni_pkg::X_MIN_RST, rrt_nni_pkg::X_MAX_RST,
                 rrt_nni_pkg::Y_MIN_RST, rrt_nni_pkg::Y_MAX_RST);
    recv_idle_pct = 50;
    push_point(8000, 8000);
    push_point(0, 0);
    push_random(16);
    wait_drained();

    if (errors == 0) begin
      $display("rrt_nearest_node_insert_test: PASS");
    end else begin
      $display("rrt_nearest_node_insert_test: FAIL");
    end
    $finish;
  end
endmodule

// File: rrt_nearest_node_insert.f
sv/rrt_nni_pkg.sv
sv/rrt_nni_ram.sv
sv/rrt_nni_cell.sv
sv/rrt_nearest_node_insert.sv
tb/rrt_nearest_node_insert_test.sv
